[sv/egpd_pkg.sv]
// Shared constants, types and register codes for the Elias gamma position decoder.
`default_nettype none

package egpd_pkg;

  // Width of the value accumulator; the longest legal zero run is VALUE_BITS-1.
  localparam int VALUE_BITS = 16;
  localparam int ZERO_W     = $clog2(VALUE_BITS);
  localparam int LEN_W      = ZERO_W + 2;
  localparam int EXT_W      = (VALUE_BITS > 16) ? VALUE_BITS : 16;

  localparam int POS_W   = 16;
  localparam int SYM_W   = 8;
  localparam int CBITS_W = 5;
  localparam int TOTAL_W = 32;
  localparam int CNT_W   = 17;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
  localparam logic [ZERO_W-1:0] ZERO_RUN_MAX  = ZERO_W'(VALUE_BITS - 1);
  localparam logic [SYM_W-1:0]  SYMBOL_RESET  = SYM_W'(32);
  localparam logic [CBITS_W-1:0] CBITS_SAT    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SKIP   = 2'd0,
    CFG_TAKE   = 2'd1,
    CFG_SYMBOL = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0]      skip_codes;
    logic [15:0]      take_codes;
    logic [SYM_W-1:0] symbol_code;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [SYM_W-1:0]   symbol_out;
    logic [CBITS_W-1:0] code_bits;
    logic [TOTAL_W-1:0] total_bits;
    logic               code_error;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

[sv/egpd_in_if.sv]
// Request channel carrying one stream bit per request.
`default_nettype none

interface egpd_in_if;
  logic valid;
  logic ready;
  logic bit_in;

  modport source (output valid, output bit_in, input ready);
  modport sink   (input valid, input bit_in, output ready);
endinterface

`default_nettype wire

[sv/egpd_out_if.sv]
// Result channel carrying one decoded code per request.
`default_nettype none

interface egpd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] position;
  logic [7:0]  symbol_out;
  logic [4:0]  code_bits;
  logic [31:0] total_bits;
  logic        code_error;
  logic        last;

  modport source (output valid, output position, output symbol_out, output code_bits,
                  output total_bits, output code_error, output last, input ready);
  modport sink   (input valid, input position, input symbol_out, input code_bits,
                  input total_bits, input code_error, input last, output ready);
endinterface

`default_nettype wire

[sv/egpd_cfg.sv]
// Configuration register file with write decode.
`default_nettype none

module egpd_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [egpd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [egpd_pkg::CFG_DATA_W-1:0]    cfg_data,
  output egpd_pkg::cfg_t                     cfg
);
  import egpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SKIP:   cfg_nxt.skip_codes  = cfg_data;
        CFG_TAKE:   cfg_nxt.take_codes  = cfg_data;
        CFG_SYMBOL: cfg_nxt.symbol_code = cfg_data[SYM_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{skip_codes: '0, take_codes: '0, symbol_code: SYMBOL_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[sv/egpd_core.sv]
// Gamma decode state and the per-bit update that forms one result.
`default_nettype none

module egpd_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              bit_in,
  input  egpd_pkg::cfg_t    cfg,
  output logic              emit,
  output egpd_pkg::result_t res
);
  import egpd_pkg::*;

  logic                  reading_r,    reading_nxt;
  logic [ZERO_W-1:0]     zero_run_r,   zero_run_nxt;
  logic [ZERO_W-1:0]     bits_left_r,  bits_left_nxt;
  logic [VALUE_BITS-1:0] value_acc_r,  value_acc_nxt;
  logic [CNT_W-1:0]      codes_seen_r, codes_seen_nxt;
  logic [TOTAL_W-1:0]    bit_total_r,  bit_total_nxt;
  logic                  finished_r,   finished_nxt;

  logic [CNT_W-1:0]      target;
  logic                  done;
  logic                  fin_code;
  logic [VALUE_BITS-1:0] fin_val;
  logic [VALUE_BITS-1:0] shifted;
  logic [ZERO_W-1:0]     left_dec;
  logic [LEN_W-1:0]      len;
  logic [TOTAL_W:0]      sum;
  logic [TOTAL_W-1:0]    total_new;
  logic [CNT_W-1:0]      seen_inc;

  assign target   = {1'b0, cfg.skip_codes} + {1'b0, cfg.take_codes};
  assign done     = finished_r || (codes_seen_r >= target);
  assign shifted  = {value_acc_r[VALUE_BITS-2:0], bit_in};
  assign left_dec = (bits_left_r != '0) ? bits_left_r - 1'b1 : '0;
  assign len      = {1'b0, zero_run_r, 1'b1};
  assign sum      = {1'b0, bit_total_r} + (TOTAL_W + 1)'(len);
  assign total_new = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign seen_inc = (codes_seen_r != CNT_MAX) ? codes_seen_r + 1'b1 : codes_seen_r;

  always_comb begin
    reading_nxt    = reading_r;
    zero_run_nxt   = zero_run_r;
    bits_left_nxt  = bits_left_r;
    value_acc_nxt  = value_acc_r;
    codes_seen_nxt = codes_seen_r;
    bit_total_nxt  = bit_total_r;
    finished_nxt   = finished_r;
    emit           = 1'b0;
    fin_code       = 1'b0;
    fin_val        = VALUE_BITS'(1);
    res            = '0;
    res.symbol_out = cfg.symbol_code;
    res.total_bits = bit_total_r;

    if (step) begin
      if (done) begin
        finished_nxt = 1'b1;
      end else if (!reading_r) begin
        if (!bit_in) begin
          if (zero_run_r == ZERO_RUN_MAX) begin
            // Zero run too long for the accumulator: report and resynchronize.
            emit           = 1'b1;
            res.code_error = 1'b1;
            zero_run_nxt   = '0;
            bits_left_nxt  = '0;
            value_acc_nxt  = '0;
          end else begin
            zero_run_nxt = zero_run_r + 1'b1;
          end
        end else begin
          value_acc_nxt = VALUE_BITS'(1);
          bits_left_nxt = zero_run_r;
          if (zero_run_r == '0) begin
            fin_code = 1'b1;
          end else begin
            reading_nxt = 1'b1;
          end
        end
      end else begin
        value_acc_nxt = shifted;
        bits_left_nxt = left_dec;
        if (left_dec == '0) begin
          fin_code = 1'b1;
          fin_val  = shifted;
        end
      end
    end

    if (fin_code) begin
      if (codes_seen_r >= {1'b0, cfg.skip_codes}) begin
        emit           = 1'b1;
        bit_total_nxt  = total_new;
        res.position   = POS_W'(EXT_W'(fin_val) - EXT_W'(1));
        res.code_bits  = (32'(len) > 32'(CBITS_SAT)) ? CBITS_SAT : CBITS_W'(len);
        res.total_bits = total_new;
        res.last       = (({1'b0, codes_seen_r} + 1'b1) == {1'b0, target});
      end
      codes_seen_nxt = seen_inc;
      if (seen_inc >= target) begin
        finished_nxt = 1'b1;
      end
      reading_nxt   = 1'b0;
      zero_run_nxt  = '0;
      bits_left_nxt = '0;
      value_acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_r    <= 1'b0;
      zero_run_r   <= '0;
      bits_left_r  <= '0;
      value_acc_r  <= '0;
      codes_seen_r <= '0;
      bit_total_r  <= '0;
      finished_r   <= 1'b0;
    end else begin
      reading_r    <= reading_nxt;
      zero_run_r   <= zero_run_nxt;
      bits_left_r  <= bits_left_nxt;
      value_acc_r  <= value_acc_nxt;
      codes_seen_r <= codes_seen_nxt;
      bit_total_r  <= bit_total_nxt;
      finished_r   <= finished_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/elias_gamma_position_decoder_top.sv]
// Top level of the Elias gamma position decoder: input stage, decode core, result register.
//
//   Channel   Dir   Handshake          Payload
//   in_ch     in    valid/ready        bit_in (one stream bit)
//   out_ch    out   valid/ready        position, symbol_out, code_bits, total_bits,
//                                      code_error, last
//   cfg_*     in    cfg_we (no wait)   cfg_index, cfg_data
//
// An accepted request is held in the input register; once the result register is
// free, the decoded result is written into the result register and becomes
// visible there.
// A new request can be accepted every cycle while the result register is free;
// it is the only thing that throttles the input when the result sink stalls.
// Reset (rst_n low at a clock edge) clears the decode state and the valid flags
// and resets the configuration (symbol code to 32); there is no clearing pass.
// Requests that produce no result (zeros of a legal run, value bits before the last one,
// skipped codes, and anything after the final code) simply drain.
`default_nettype none

module elias_gamma_position_decoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  egpd_in_if.sink                         in_ch,
  egpd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [egpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [egpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import egpd_pkg::*;

  cfg_t    cfg;
  logic    emit;
  result_t res;

  // Input register: holds one accepted bit until the decode stage takes it.
  logic    stg_valid_r, stg_valid_nxt;
  logic    stg_bit_r;

  // Result register: the decoded code waiting for the sink.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic    out_free;
  logic    step;
  logic    in_fire;

  // The decode stage may run whenever the result register is empty or being drained.
  assign out_free = !out_valid_r || out_ch.ready;
  assign step     = stg_valid_r && out_free;
  assign in_ch.ready = !stg_valid_r || out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_fire) begin
      stg_valid_nxt = 1'b1;
    end else if (step) begin
      stg_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_bit_r <= in_ch.bit_in;
    end
    if (step && emit) begin
      out_res_r <= res;
    end
  end

  egpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  egpd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .bit_in (stg_bit_r),
    .cfg    (cfg),
    .emit   (emit),
    .res    (res)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.position   = out_res_r.position;
  assign out_ch.symbol_out = out_res_r.symbol_out;
  assign out_ch.code_bits  = out_res_r.code_bits;
  assign out_ch.total_bits = out_res_r.total_bits;
  assign out_ch.code_error = out_res_r.code_error;
  assign out_ch.last       = out_res_r.last;

endmodule

`default_nettype wire

[sv/egpd_checker.sv]
// Port-level assertions for the decoder and the bind that attaches them.
`default_nettype none

module egpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] position,
  input logic [4:0]  code_bits,
  input logic [31:0] total_bits,
  input logic        code_error,
  input logic        last
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(position) && $stable(code_bits)
      && $stable(total_bits) && $stable(code_error) && $stable(last))
    else $error("result changed while stalled");

  // An error result carries no position, no length and is never the final code.
  a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && code_error |-> position == 16'd0 && code_bits == 5'd0 && !last)
    else $error("error result carries code fields");

  // A real code always has an odd length.
  a_odd_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !code_error |-> code_bits[0])
    else $error("code length is even");

  // Once the final code is delivered, the result valid drops.
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last |=> !out_valid)
    else $error("result after the final code");

endmodule

bind elias_gamma_position_decoder_top egpd_checker u_egpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .position   (out_ch.position),
  .code_bits  (out_ch.code_bits),
  .total_bits (out_ch.total_bits),
  .code_error (out_ch.code_error),
  .last       (out_ch.last)
);

`default_nettype wire
